// ===== hw/rtl/bpgs_pkg.sv =====
// Shared types, constants and lookup tables for the button panel gear selector.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package bpgs_pkg;

    // Field widths
    localparam int ID_W    = 11;
    localparam int KEYS_W  = 8;
    localparam int MODE_W  = 2;
    localparam int SOC_W   = 10;
    localparam int GEAR_W  = 2;
    localparam int MASK_W  = 6;

    // Configuration port
    localparam int NUM_LEVELS = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SOC_W;

    // Panel frame identifier
    localparam logic [ID_W-1:0] PANEL_ID = 11'h195;

    // Key bits, shared by the frame byte and the LED masks
    localparam logic [MASK_W-1:0] KEY_DRIVE   = 6'h01;
    localparam logic [MASK_W-1:0] KEY_NEUTRAL = 6'h02;
    localparam logic [MASK_W-1:0] KEY_REVERSE = 6'h04;
    localparam logic [MASK_W-1:0] KEY_PARK    = 6'h08;
    localparam logic [MASK_W-1:0] KEY_REGEN   = 6'h10;
    localparam logic [MASK_W-1:0] KEY_HEAT    = 6'h20;

    // Gear codes
    localparam logic [GEAR_W-1:0] GEAR_PARK    = 2'd0;
    localparam logic [GEAR_W-1:0] GEAR_REVERSE = 2'd1;
    localparam logic [GEAR_W-1:0] GEAR_NEUTRAL = 2'd2;
    localparam logic [GEAR_W-1:0] GEAR_DRIVE   = 2'd3;

    // Operating modes
    localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUN    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHARGE = 2'd2;

    // Item kinds
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Key lit by each SoC bar, lowest threshold first
    localparam logic [MASK_W-1:0] BAR_KEY [NUM_LEVELS] = '{
        KEY_HEAT, KEY_REVERSE, KEY_REGEN, KEY_NEUTRAL, KEY_PARK, KEY_DRIVE
    };

    // Threshold values after reset, tenths of a percent
    localparam logic [SOC_W-1:0] LEVEL_RESET [NUM_LEVELS] = '{
        10'd166, 10'd322, 10'd498, 10'd664, 10'd830, 10'd990
    };

    typedef logic [NUM_LEVELS-1:0][SOC_W-1:0] levels_t;

    typedef struct packed {
        logic              command;
        logic [ID_W-1:0]   message_id;
        logic [KEYS_W-1:0] key_bits;
        logic              brake_pressed;
        logic [MODE_W-1:0] operating_mode;
        logic [SOC_W-1:0]  charge_level;
    } item_t;

    typedef struct packed {
        logic [GEAR_W-1:0] selected_gear;
        logic              regen_off;
        logic              heat_request;
        logic              lamp_frame_valid;
        logic [MASK_W-1:0] red_mask;
        logic [MASK_W-1:0] green_mask;
        logic [MASK_W-1:0] blue_mask;
    } result_t;

    // Key that shows a gear
    function automatic logic [MASK_W-1:0] gear_key(input logic [GEAR_W-1:0] gear);
        logic [MASK_W-1:0] key;
        case (gear)
            GEAR_PARK:    key = KEY_PARK;
            GEAR_REVERSE: key = KEY_REVERSE;
            GEAR_NEUTRAL: key = KEY_NEUTRAL;
            GEAR_DRIVE:   key = KEY_DRIVE;
            default:      key = KEY_PARK;
        endcase
        return key;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bpgs_if.sv =====
// Valid/ready channel interfaces for panel items and panel results.
// Depends on bpgs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bpgs_in_if
    import bpgs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              command;
    logic [ID_W-1:0]   message_id;
    logic [KEYS_W-1:0] key_bits;
    logic              brake_pressed;
    logic [MODE_W-1:0] operating_mode;
    logic [SOC_W-1:0]  charge_level;

    modport source (
        output valid, command, message_id, key_bits, brake_pressed,
               operating_mode, charge_level,
        input  ready
    );
    modport sink (
        input  valid, command, message_id, key_bits, brake_pressed,
               operating_mode, charge_level,
        output ready
    );
endinterface

interface bpgs_out_if
    import bpgs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [GEAR_W-1:0] selected_gear;
    logic              regen_off;
    logic              heat_request;
    logic              lamp_frame_valid;
    logic [MASK_W-1:0] red_mask;
    logic [MASK_W-1:0] green_mask;
    logic [MASK_W-1:0] blue_mask;

    modport source (
        output valid, selected_gear, regen_off, heat_request, lamp_frame_valid,
               red_mask, green_mask, blue_mask,
        input  ready
    );
    modport sink (
        input  valid, selected_gear, regen_off, heat_request, lamp_frame_valid,
               red_mask, green_mask, blue_mask,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/bpgs_cfg_regs.sv =====
// SoC threshold registers written through the plain configuration port.
// Depends on bpgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpgs_cfg_regs
    import bpgs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output levels_t                    levels
);

    levels_t levels_reg;

    // Write one threshold; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                levels_reg[i] <= LEVEL_RESET[i];
            end
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_LEVELS)))
        begin
            levels_reg[cfg_index] <= cfg_data[SOC_W-1:0];
        end
    end

    assign levels = levels_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bpgs_in_stage.sv =====
// Input register: captures one panel item per transfer.
// Depends on bpgs_pkg and bpgs_in_if.
`timescale 1ns / 1ps
`default_nettype none

module bpgs_in_stage
    import bpgs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    bpgs_in_if.sink    in_ch,
    input  wire logic  advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    item_t item_reg;

    // Take a new item whenever the held one moves on or the register is empty
    assign in_ch.ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            valid_reg <= in_ch.valid;
        end
    end

    // Capture payload on a transfer
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg.command        <= in_ch.command;
            item_reg.message_id     <= in_ch.message_id;
            item_reg.key_bits       <= in_ch.key_bits;
            item_reg.brake_pressed  <= in_ch.brake_pressed;
            item_reg.operating_mode <= in_ch.operating_mode;
            item_reg.charge_level   <= in_ch.charge_level;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bpgs_step.sv =====
// Panel state (gear, key history, flags, blink) and the per-item update logic.
// Depends on bpgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpgs_step
    import bpgs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic advance,
    input  item_t     item,
    input  levels_t   levels,
    output result_t   result
);

    logic [GEAR_W-1:0] gear_reg,   gear_next;
    logic [KEYS_W-1:0] keys_reg,   keys_next;
    logic              regen_reg,  regen_next;
    logic              heater_reg, heater_next;
    logic              blink_reg,  blink_next;

    logic [KEYS_W-1:0] pressed;
    logic              allow;
    logic              found;
    logic [MASK_W-1:0] bars;
    logic [MASK_W-1:0] blue;
    logic              lamp;

    always_comb
    begin
        gear_next   = gear_reg;
        keys_next   = keys_reg;
        regen_next  = regen_reg;
        heater_next = heater_reg;
        blink_next  = blink_reg;
        pressed     = '0;
        allow       = 1'b0;
        found       = 1'b0;
        bars        = '0;
        blue        = '0;
        lamp        = 1'b0;

        if (item.command == CMD_FRAME)
        begin
            // Rising key edges, later keys overriding earlier ones
            if (item.message_id == PANEL_ID)
            begin
                pressed = item.key_bits & ~keys_reg;
                allow   = (gear_reg != GEAR_PARK) || item.brake_pressed;
                if (|(pressed[MASK_W-1:0] & KEY_DRIVE) && allow)
                begin
                    gear_next = GEAR_DRIVE;
                end
                if (|(pressed[MASK_W-1:0] & KEY_REVERSE) && allow)
                begin
                    gear_next = GEAR_REVERSE;
                end
                if (|(pressed[MASK_W-1:0] & KEY_NEUTRAL) && allow)
                begin
                    gear_next = GEAR_NEUTRAL;
                end
                if (|(pressed[MASK_W-1:0] & KEY_PARK))
                begin
                    gear_next = GEAR_PARK;
                end
                if (|(pressed[MASK_W-1:0] & KEY_REGEN))
                begin
                    regen_next = ~regen_reg;
                end
                if (|(pressed[MASK_W-1:0] & KEY_HEAT))
                begin
                    heater_next = ~heater_reg;
                end
                keys_next = item.key_bits;
            end
        end
        else
        begin
            // Tick: force neutral when off, flip blink, build LED masks
            if (item.operating_mode == MODE_OFF)
            begin
                gear_next = GEAR_NEUTRAL;
            end
            blink_next = ~blink_reg;
            lamp       = 1'b1;

            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                if (item.charge_level > levels[i])
                begin
                    bars = bars | BAR_KEY[i];
                end
            end

            // Charging blink: first threshold still above the level
            if ((item.operating_mode == MODE_CHARGE) && blink_next)
            begin
                for (int i = 0; i < NUM_LEVELS; i++)
                begin
                    if (!found && (item.charge_level < levels[i]))
                    begin
                        bars  = bars | BAR_KEY[i];
                        found = 1'b1;
                    end
                end
            end

            if (item.operating_mode == MODE_RUN)
            begin
                blue = gear_key(gear_next);
                bars = bars & ~blue;
                if (regen_reg)
                begin
                    blue = KEY_REGEN;
                    bars = bars & ~KEY_REGEN;
                end
            end

            if (heater_reg)
            begin
                blue = KEY_HEAT;
                bars = bars & ~KEY_HEAT;
            end
        end

        result.selected_gear    = gear_next;
        result.regen_off        = regen_next;
        result.heat_request     = heater_next;
        result.lamp_frame_valid = lamp;
        result.red_mask         = bars;
        result.green_mask       = bars;
        result.blue_mask        = blue;
    end

    // Commit state as each item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gear_reg   <= GEAR_PARK;
            keys_reg   <= '0;
            regen_reg  <= 1'b0;
            heater_reg <= 1'b0;
            blink_reg  <= 1'b0;
        end
        else if (advance)
        begin
            gear_reg   <= gear_next;
            keys_reg   <= keys_next;
            regen_reg  <= regen_next;
            heater_reg <= heater_next;
            blink_reg  <= blink_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bpgs_out_stage.sv =====
// Result register driving the output channel.
// Depends on bpgs_pkg and bpgs_out_if.
`timescale 1ns / 1ps
`default_nettype none

module bpgs_out_stage
    import bpgs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  load,
    input  result_t    result,
    output logic       space,
    bpgs_out_if.source out_ch
);

    logic    valid_reg;
    result_t result_reg;

    // Room for a new result when empty or when the held one transfers now
    assign space = !valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Hold payload until the next load
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_ch.valid            = valid_reg;
    assign out_ch.selected_gear    = result_reg.selected_gear;
    assign out_ch.regen_off        = result_reg.regen_off;
    assign out_ch.heat_request     = result_reg.heat_request;
    assign out_ch.lamp_frame_valid = result_reg.lamp_frame_valid;
    assign out_ch.red_mask         = result_reg.red_mask;
    assign out_ch.green_mask       = result_reg.green_mask;
    assign out_ch.blue_mask        = result_reg.blue_mask;

endmodule

`default_nettype wire

// ===== hw/rtl/button_panel_gear_selector_top.sv =====
// Button panel gear selector: six-key panel handling and LED mask generation.
//
// Channels: in_ch takes panel items (a received frame or a 100 ms tick),
// out_ch returns exactly one result per item, in order. Both use valid/ready;
// a transfer happens on a rising edge with valid and ready high.
// Configuration: cfg_we, cfg_index and cfg_data write the six SoC thresholds
// (index 0 to 5); other indexes are ignored. Write only while idle.
// Path: an item transferred on in_ch sits in the input register, passes through
// the update logic and moves into the result register once that register has
// room (two register stages).
// Throughput: one item per clock while out_ch.ready stays high; the state update
// between the input and result registers is combinational.
// Reset (rst_n low, asynchronous): both registers empty, gear park, key
// history, flags and blink phase clear, thresholds back to their defaults.
// Stall: while out_ch.ready is low the result holds; one more item is held in
// the input register, after which in_ch.ready drops.
// Depends on bpgs_pkg, bpgs_if and the bpgs_* stage modules.
`timescale 1ns / 1ps
`default_nettype none

module button_panel_gear_selector_top
    import bpgs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    bpgs_in_if.sink                    in_ch,
    bpgs_out_if.source                 out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    levels_t levels;
    item_t   item;
    result_t result;
    logic    item_valid;
    logic    space;
    logic    advance;

    // Move the held item on when the result register has room
    assign advance = item_valid && space;

    bpgs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .levels    (levels)
    );

    bpgs_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    bpgs_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .levels  (levels),
        .result  (result)
    );

    bpgs_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .result (result),
        .space  (space),
        .out_ch (out_ch)
    );

`ifndef SYNTHESIS
    // A moved item always shows up as a result
    a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_ch.valid)
        else $error("result missing after item advanced");

    // Frame results carry no LED masks
    a_frame_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.lamp_frame_valid) |->
        (out_ch.red_mask == '0 && out_ch.green_mask == '0 && out_ch.blue_mask == '0))
        else $error("LED masks set on a frame result");

    // Blue lights at most one key, and red tracks green
    a_mask_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> ($onehot0(out_ch.blue_mask) &&
                          out_ch.red_mask == out_ch.green_mask))
        else $error("malformed LED masks");
`endif

endmodule

`default_nettype wire

// ===== bench/button_panel_gear_selector_top_tb.sv =====
// Self-checking bench for the button panel gear selector: drives frames and ticks,
// predicts gear, flags and LED masks, and checks every result in order.
// Depends on bpgs_pkg, bpgs_if and the button_panel_gear_selector_top RTL.
`timescale 1ns / 1ps

module button_panel_gear_selector_top_tb;
    import bpgs_pkg::*;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_ONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_TWO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THREE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_FOUR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_FIVE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_SIX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] LEVEL_REG [NUM_LEVELS] = '{
        REG_LEVEL_ONE, REG_LEVEL_TWO, REG_LEVEL_THREE,
        REG_LEVEL_FOUR, REG_LEVEL_FIVE, REG_LEVEL_SIX
    };

    localparam logic [MODE_W-1:0] MODE_OTHER = 2'd3;
    localparam logic [SOC_W-1:0]  SOC_MAX    = 10'd1023;

    // Key shown for each gear code
    localparam logic [MASK_W-1:0] GEAR_LAMP [4] = '{KEY_PARK, KEY_REVERSE, KEY_NEUTRAL, KEY_DRIVE};

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int STALL_LIMIT     = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bpgs_in_if  in_ch ();
    bpgs_out_if out_ch ();

    button_panel_gear_selector_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Shadow of the block's state and thresholds
    logic [GEAR_W-1:0] gear_now    = GEAR_PARK;
    logic [KEYS_W-1:0] keys_prev   = '0;
    logic              regen_now   = 1'b0;
    logic              heater_now  = 1'b0;
    logic              blink_now   = 1'b0;
    logic [SOC_W-1:0]  soc_limit [NUM_LEVELS];

    item_t   pending_items [$];
    result_t predicted_results [$];

    logic steady = 1'b0;
    logic in_fire = 1'b0;
    int   send_gap = 0;
    int   hold_gap = 0;
    int   stall_cycles = 0;
    int   fail_count = 0;
    int   panel_frames = 0;
    int   foreign_frames = 0;
    int   tick_items = 0;
    int   results_checked = 0;

    // Work out the result of one item and advance the shadow state
    task automatic predict_panel(input item_t it, output result_t res);
        logic [KEYS_W-1:0] rising;
        logic              allow;
        logic [MASK_W-1:0] bars;
        logic [MASK_W-1:0] lamp;
        logic              found;
        res = '0;
        if (it.command == CMD_FRAME) begin
            if (it.message_id == PANEL_ID) begin
                rising = it.key_bits & ~keys_prev;
                allow  = (gear_now != GEAR_PARK) || it.brake_pressed;
                // Later gear keys override earlier ones; park needs no permission
                if (|(rising[MASK_W-1:0] & KEY_DRIVE) && allow)
                    gear_now = GEAR_DRIVE;
                if (|(rising[MASK_W-1:0] & KEY_REVERSE) && allow)
                    gear_now = GEAR_REVERSE;
                if (|(rising[MASK_W-1:0] & KEY_NEUTRAL) && allow)
                    gear_now = GEAR_NEUTRAL;
                if (|(rising[MASK_W-1:0] & KEY_PARK))
                    gear_now = GEAR_PARK;
                if (|(rising[MASK_W-1:0] & KEY_REGEN))
                    regen_now = ~regen_now;
                if (|(rising[MASK_W-1:0] & KEY_HEAT))
                    heater_now = ~heater_now;
                keys_prev = it.key_bits;
            end
        end
        else begin
            if (it.operating_mode == MODE_OFF)
                gear_now = GEAR_NEUTRAL;
            blink_now = ~blink_now;
            bars = '0;
            lamp = '0;
            for (int i = 0; i < NUM_LEVELS; i++)
                if (it.charge_level > soc_limit[i])
                    bars |= BAR_KEY[i];
            // Blinking bar while charging: first threshold still above the level
            if (it.operating_mode == MODE_CHARGE && blink_now) begin
                found = 1'b0;
                for (int i = 0; i < NUM_LEVELS; i++)
                    if (!found && it.charge_level < soc_limit[i]) begin
                        bars |= BAR_KEY[i];
                        found = 1'b1;
                    end
            end
            if (it.operating_mode == MODE_RUN) begin
                lamp = GEAR_LAMP[gear_now];
                bars &= ~lamp;
                if (regen_now) begin
                    lamp = KEY_REGEN;
                    bars &= ~KEY_REGEN;
                end
            end
            if (heater_now) begin
                lamp = KEY_HEAT;
                bars &= ~KEY_HEAT;
            end
            res.lamp_frame_valid = 1'b1;
            res.red_mask   = bars;
            res.green_mask = bars;
            res.blue_mask  = lamp;
        end
        res.selected_gear = gear_now;
        res.regen_off     = regen_now;
        res.heat_request  = heater_now;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Charge level biased towards the current thresholds and the extremes
    function automatic logic [SOC_W-1:0] pick_charge();
        int pick;
        int v;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            v = soc_limit[$urandom_range(0, NUM_LEVELS - 1)];
            v = v + int'($urandom_range(0, 2)) - 1;
            if (v < 0)
                v = 0;
            if (v > SOC_MAX)
                v = SOC_MAX;
            return v[SOC_W-1:0];
        end
        else if (pick == 5)
            return '0;
        else if (pick == 6)
            return SOC_MAX;
        return SOC_W'($urandom_range(0, SOC_MAX));
    endfunction

    // Mostly panel frames and ticks, with some frames from other nodes
    function automatic item_t random_item();
        item_t it;
        int    pick;
        int    keys_pick;
        int    mode_pick;
        it.command        = CMD_FRAME;
        it.message_id     = ID_W'($urandom);
        it.key_bits       = KEYS_W'($urandom);
        it.brake_pressed  = 1'($urandom);
        it.operating_mode = MODE_W'($urandom);
        it.charge_level   = SOC_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            if (it.message_id == PANEL_ID)
                it.message_id = ~PANEL_ID;
        end
        else if (pick < 60) begin
            it.message_id = PANEL_ID;
            keys_pick = $urandom_range(0, 9);
            if (keys_pick < 3)
                it.key_bits = '0;
            else if (keys_pick < 7)
                it.key_bits = 8'd1 << $urandom_range(0, MASK_W - 1);
        end
        else begin
            it.command = CMD_TICK;
            mode_pick = $urandom_range(0, 19);
            if (mode_pick < 3)
                it.operating_mode = MODE_OFF;
            else if (mode_pick < 10)
                it.operating_mode = MODE_RUN;
            else if (mode_pick < 17)
                it.operating_mode = MODE_CHARGE;
            else
                it.operating_mode = MODE_OTHER;
            it.charge_level = pick_charge();
        end
        return it;
    endfunction

    task automatic push_frame(input logic [ID_W-1:0] id, input logic [KEYS_W-1:0] keys,
                              input logic brake);
        item_t it;
        it = random_item();
        it.command       = CMD_FRAME;
        it.message_id    = id;
        it.key_bits      = keys;
        it.brake_pressed = brake;
        pending_items.push_back(it);
    endtask

    task automatic push_tick(input logic [MODE_W-1:0] mode, input logic [SOC_W-1:0] soc);
        item_t it;
        it = random_item();
        it.command        = CMD_TICK;
        it.operating_mode = mode;
        it.charge_level   = soc;
        pending_items.push_back(it);
    endtask

    // Threshold writes go in only while nothing is in flight
    task automatic write_level(input logic [CFG_IDX_W-1:0] idx, input logic [SOC_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx < NUM_LEVELS)
            soc_limit[idx] = value;
    endtask

    // Hold until every queued item has been sent and every result checked
    task automatic wait_drained();
        while (pending_items.size() != 0 || in_ch.valid || predicted_results.size() != 0) begin
            @(posedge clk);
            #1;
        end
        repeat (3) @(posedge clk);
    endtask

    // Sender: new item only when the line is free or the last one transferred
    always @(negedge clk) begin : feed_items
        item_t head;
        if (rst_n && (!in_ch.valid || in_fire)) begin
            if (send_gap > 0) begin
                send_gap    <= send_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 11) == 0) begin
                send_gap    <= $urandom_range(0, 7);
                in_ch.valid <= 1'b0;
            end
            else if (pending_items.size() != 0) begin
                head = pending_items.pop_front();
                in_ch.valid          <= 1'b1;
                in_ch.command        <= head.command;
                in_ch.message_id     <= head.message_id;
                in_ch.key_bits       <= head.key_bits;
                in_ch.brake_pressed  <= head.brake_pressed;
                in_ch.operating_mode <= head.operating_mode;
                in_ch.charge_level   <= head.charge_level;
            end
            else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: stall in random bursts
    always @(negedge clk) begin : drain_results
        if (rst_n) begin
            if (hold_gap > 0) begin
                hold_gap     <= hold_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 9) == 0) begin
                hold_gap     <= $urandom_range(0, 7);
                out_ch.ready <= 1'b0;
            end
            else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Predict on every input transfer
    always @(posedge clk) begin : track_items
        item_t   seen;
        result_t res;
        in_fire <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready) begin
            seen.command        = in_ch.command;
            seen.message_id     = in_ch.message_id;
            seen.key_bits       = in_ch.key_bits;
            seen.brake_pressed  = in_ch.brake_pressed;
            seen.operating_mode = in_ch.operating_mode;
            seen.charge_level   = in_ch.charge_level;
            predict_panel(seen, res);
            predicted_results.push_back(res);
            if (seen.command == CMD_TICK)
                tick_items++;
            else if (seen.message_id == PANEL_ID)
                panel_frames++;
            else
                foreign_frames++;
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk) begin : check_results
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (predicted_results.size() == 0) begin
                $error("result transfer with no item outstanding");
                fail_count++;
            end
            else begin
                want = predicted_results.pop_front();
                check_field("selected_gear", 8'(want.selected_gear),
                            8'(out_ch.selected_gear));
                check_field("regen_off", 8'(want.regen_off), 8'(out_ch.regen_off));
                check_field("heat_request", 8'(want.heat_request),
                            8'(out_ch.heat_request));
                check_field("lamp_frame_valid", 8'(want.lamp_frame_valid),
                            8'(out_ch.lamp_frame_valid));
                check_field("red_mask", 8'(want.red_mask), 8'(out_ch.red_mask));
                check_field("green_mask", 8'(want.green_mask), 8'(out_ch.green_mask));
                check_field("blue_mask", 8'(want.blue_mask), 8'(out_ch.blue_mask));
                results_checked++;
            end
        end
    end

    // Abort when transfers stop for too long
    always @(posedge clk) begin : watchdog
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles == STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : stimulus
        logic [SOC_W-1:0] lv [NUM_LEVELS];
        item_t it;
        int    acc;
        int    counted;
        in_ch.valid          = 1'b0;
        in_ch.command        = CMD_FRAME;
        in_ch.message_id     = '0;
        in_ch.key_bits       = '0;
        in_ch.brake_pressed  = 1'b0;
        in_ch.operating_mode = MODE_OFF;
        in_ch.charge_level   = '0;
        out_ch.ready         = 1'b0;
        for (int i = 0; i < NUM_LEVELS; i++)
            soc_limit[i] = LEVEL_RESET[i];

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: gear permission, key order, foreign ids, overrides, blink cases
        push_frame(PANEL_ID, {2'b00, KEY_DRIVE}, 1'b0);
        push_frame(PANEL_ID, '0, 1'b0);
        push_frame(PANEL_ID, {2'b00, KEY_REVERSE}, 1'b1);
        push_frame(PANEL_ID, {2'b00, KEY_REVERSE | KEY_DRIVE | KEY_NEUTRAL}, 1'b0);
        push_frame(PANEL_ID, '0, 1'b0);
        push_frame(PANEL_ID, 8'hFF, 1'b0);
        push_frame(PANEL_ID ^ 11'h001, '0, 1'b0);
        push_frame(PANEL_ID, 8'hFF, 1'b1);
        push_frame(11'h7FF, '0, 1'b1);
        push_frame('0, {2'b00, KEY_HEAT | KEY_REGEN}, 1'b0);
        push_tick(MODE_RUN, SOC_MAX);
        push_frame(PANEL_ID, '0, 1'b0);
        push_frame(PANEL_ID, {2'b00, KEY_REGEN | KEY_HEAT}, 1'b0);
        push_tick(MODE_RUN, SOC_MAX);
        push_tick(MODE_OFF, '0);
        push_tick(MODE_CHARGE, LEVEL_RESET[0]);
        push_tick(MODE_CHARGE, LEVEL_RESET[0]);
        push_tick(MODE_CHARGE, '0);
        push_tick(MODE_CHARGE, '0);
        push_tick(MODE_CHARGE, SOC_MAX);
        push_tick(MODE_CHARGE, SOC_MAX);
        push_tick(MODE_OTHER, 10'd500);
        push_frame(PANEL_ID, 8'hC0, 1'b0);
        push_frame(PANEL_ID, {2'b00, KEY_DRIVE}, 1'b0);
        push_tick(MODE_RUN, 10'd665);
        wait_drained();

        // Random phases, each under its own threshold setting
        for (int p = 1; p <= PHASES; p++) begin
            case (p)
                1: for (int i = 0; i < NUM_LEVELS; i++) lv[i] = '0;
                2: for (int i = 0; i < NUM_LEVELS; i++) lv[i] = SOC_MAX;
                4: for (int i = 0; i < NUM_LEVELS; i++) lv[i] = SOC_W'($urandom);
                5: begin
                    lv[0] = SOC_W'($urandom);
                    for (int i = 1; i < NUM_LEVELS; i++) lv[i] = lv[0];
                end
                6: begin
                    acc = $urandom_range(0, SOC_MAX - 20);
                    for (int i = 0; i < NUM_LEVELS; i++) lv[i] = SOC_W'(acc + 2 * i);
                end
                7: for (int i = 0; i < NUM_LEVELS; i++) lv[i] = LEVEL_RESET[i];
                default: begin
                    acc = 0;
                    for (int i = 0; i < NUM_LEVELS; i++) begin
                        acc = acc + int'($urandom_range(0, 170));
                        if (acc > SOC_MAX)
                            acc = SOC_MAX;
                        lv[i] = SOC_W'(acc);
                    end
                end
            endcase
            for (int i = 0; i < NUM_LEVELS; i++)
                write_level(LEVEL_REG[i], lv[i]);
            if (p == 4)
                write_level(REG_SPARE, SOC_W'($urandom));

            // Last phase runs with both sides flat out
            if (p == PHASES)
                steady = 1'b1;
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                it = random_item();
                pending_items.push_back(it);
                counted++;
            end
            wait_drained();
        end

        $display("tb: covered %0d panel frames, %0d foreign frames and %0d ticks",
                 panel_frames, foreign_frames, tick_items);
        $display("tb: %0d results checked over %0d threshold settings",
                 results_checked, PHASES + 1);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
